[design/mcts_pkg.sv]
// ----------------------------------------------------------------------------
// mcts_pkg
// Shared constants and types for the multi-channel timing statistics block.
// ----------------------------------------------------------------------------
package mcts_pkg;

    localparam int DEF_CHANNEL_COUNT = 6;
    localparam int DATA_W            = 32;
    localparam int IDX_W             = 3;
    localparam logic [DATA_W-1:0] ONE = 32'd1;

    // register map
    localparam logic [1:0] REG_LOOP_BUDGET = 2'd0;

    // per-item command from the sequencer to each lane
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] n;
    } lane_cmd_t;

endpackage

[design/mcts_lane.sv]
// ----------------------------------------------------------------------------
// mcts_lane
// One channel: recent, peak and cumulative mean with a restoring divider
// that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mcts_lane
    import mcts_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lane_cmd_t         cmd,
    input  logic [DATA_W-1:0] sample,
    output logic              busy,
    output logic [DATA_W-1:0] recent,
    output logic [DATA_W-1:0] mean,
    output logic [DATA_W-1:0] peak
);

    localparam int CNT_W = $clog2(2*DATA_W+1);

    logic [DATA_W-1:0]   recent_reg, mean_reg, peak_reg;
    logic [DATA_W-1:0]   div_reg;
    logic [2*DATA_W-1:0] dividend_reg;
    logic [DATA_W:0]     rem_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic                mul_reg, run_reg;
    logic [DATA_W-1:0]   old_n1;

    logic [DATA_W:0]     rem_shift;
    logic [DATA_W:0]     rem_sub;
    logic                take;

    assign old_n1    = cmd.n - ONE;
    assign rem_shift = {rem_reg[DATA_W-1:0], dividend_reg[2*DATA_W-1]};
    assign rem_sub   = rem_shift - {1'b0, div_reg};
    assign take      = !rem_sub[DATA_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg <= '0;
            mean_reg   <= '0;
            peak_reg   <= '0;
            mul_reg    <= 1'b0;
            run_reg    <= 1'b0;
            cnt_reg    <= '0;
        end
        else if (cmd.start)
        begin
            recent_reg <= sample;
            if (sample > peak_reg)
                peak_reg <= sample;
            div_reg <= cmd.n;
            if (cmd.n <= ONE)
                mean_reg <= sample;
            else
            begin
                // product formed next cycle, then the shift-subtract loop
                dividend_reg <= {32'd0, old_n1};
                mul_reg      <= 1'b1;
            end
        end
        else if (mul_reg)
        begin
            dividend_reg <= 64'(mean_reg) * 64'(dividend_reg[DATA_W-1:0])
                            + 64'(recent_reg);
            rem_reg  <= '0;
            cnt_reg  <= CNT_W'(2*DATA_W);
            mul_reg  <= 1'b0;
            run_reg  <= 1'b1;
        end
        else if (run_reg)
        begin
            rem_reg      <= take ? rem_sub : rem_shift;
            dividend_reg <= {dividend_reg[2*DATA_W-2:0], take};
            cnt_reg      <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                run_reg  <= 1'b0;
                mean_reg <= {dividend_reg[DATA_W-2:0], take};
            end
        end
    end

    assign busy   = mul_reg | run_reg;
    assign recent = recent_reg;
    assign mean   = mean_reg;
    assign peak   = peak_reg;

endmodule

[design/mcts_merge.sv]
// ----------------------------------------------------------------------------
// mcts_merge
// Serializes the lane results, one item per channel, behind an output
// register.
// ----------------------------------------------------------------------------
module mcts_merge
    import mcts_pkg::*;
#(
    parameter int CHANNEL_COUNT = DEF_CHANNEL_COUNT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              go,
    input  logic [DATA_W-1:0] recent_in [CHANNEL_COUNT],
    input  logic [DATA_W-1:0] mean_in   [CHANNEL_COUNT],
    input  logic [DATA_W-1:0] peak_in   [CHANNEL_COUNT],
    output logic              active,
    output logic              valid,
    input  logic              stall,
    output logic [IDX_W-1:0]  index,
    output logic [DATA_W-1:0] recent,
    output logic [DATA_W-1:0] mean,
    output logic [DATA_W-1:0] peak,
    output logic              last
);

    localparam int SEL_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;

    logic [SEL_W-1:0] sel_reg;
    logic             active_reg, valid_reg;
    logic [IDX_W-1:0] index_reg;
    logic [DATA_W-1:0] recent_reg, mean_reg, peak_reg;
    logic              last_reg;
    logic              load;

    assign load = active_reg && (!valid_reg || !stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg    <= '0;
            active_reg <= 1'b0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            if (valid_reg && !stall && !load)
                valid_reg <= 1'b0;
            if (go)
            begin
                active_reg <= 1'b1;
                sel_reg    <= '0;
            end
            else if (load)
            begin
                valid_reg  <= 1'b1;
                index_reg  <= IDX_W'(sel_reg);
                recent_reg <= recent_in[sel_reg];
                mean_reg   <= mean_in[sel_reg];
                peak_reg   <= peak_in[sel_reg];
                last_reg   <= (sel_reg == SEL_W'(CHANNEL_COUNT-1));
                if (sel_reg == SEL_W'(CHANNEL_COUNT-1))
                    active_reg <= 1'b0;
                else
                    sel_reg <= sel_reg + 1'b1;
            end
        end
    end

    assign active = active_reg | valid_reg;
    assign valid  = valid_reg;
    assign index  = index_reg;
    assign recent = recent_reg;
    assign mean   = mean_reg;
    assign peak   = peak_reg;
    assign last   = last_reg;

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (load && sel_reg == SEL_W'(CHANNEL_COUNT-1)) |=> !active_reg)
        else $error("merge kept running after last channel");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && stall) |=> valid_reg && $stable(index_reg))
        else $error("stalled result changed");
    a_no_go_busy: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> !active_reg)
        else $error("new item started while results pending");

endmodule

[design/multi_channel_timing_statistics_top.sv]
// ----------------------------------------------------------------------------
// multi_channel_timing_statistics_top
// Per-channel last/peak/mean statistics with an over-budget monitor.
// ----------------------------------------------------------------------------
// From item acceptance to the first result: a multiply step, then a 64-step
// restoring divide in each lane (none for the first item), then the merge.
// New items are stalled until the merge has emitted every result; lane
// dividers run in parallel; merge emits one result per cycle unless stalled.
// Reset clears all statistics, counters and the budget register at once.
module multi_channel_timing_statistics_top
    import mcts_pkg::*;
#(
    parameter int CHANNEL_COUNT = DEF_CHANNEL_COUNT
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [1:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [DATA_W-1:0] loop_sample_us,
    input  logic [DATA_W-1:0] transport_sample_us,
    input  logic [DATA_W-1:0] transmit_stage_sample_us,
    input  logic [DATA_W-1:0] receive_sync_sample_us,
    input  logic [DATA_W-1:0] publish_sample_us,
    input  logic [DATA_W-1:0] housekeeping_sample_us,
    input  logic [DATA_W-1:0] timestamp_ms,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [IDX_W-1:0]  channel_index,
    output logic [DATA_W-1:0] recent_sample_us,
    output logic [DATA_W-1:0] mean_us,
    output logic [DATA_W-1:0] peak_us,
    output logic [DATA_W-1:0] iteration_total,
    output logic [DATA_W-1:0] over_budget_total,
    output logic [DATA_W-1:0] over_budget_stamp_ms,
    output logic              over_budget_now,
    output logic              last_of_run
);

    logic [DATA_W-1:0] budget_reg, iter_reg, ob_cnt_reg, ob_time_reg;
    logic              ob_now_reg, wait_reg;
    logic [DATA_W-1:0] samples [CHANNEL_COUNT];
    logic [DATA_W-1:0] rec_w [CHANNEL_COUNT];
    logic [DATA_W-1:0] mean_w [CHANNEL_COUNT];
    logic [DATA_W-1:0] peak_w [CHANNEL_COUNT];
    logic [CHANNEL_COUNT-1:0] busy_w;
    logic              merge_active, accept, over, go;
    lane_cmd_t         cmd;
    logic [DATA_W-1:0] all_in [8];

    assign pready = 1'b1;
    assign prdata = (paddr == REG_LOOP_BUDGET) ? budget_reg : '0;

    assign all_in[0] = loop_sample_us;
    assign all_in[1] = transport_sample_us;
    assign all_in[2] = transmit_stage_sample_us;
    assign all_in[3] = receive_sync_sample_us;
    assign all_in[4] = publish_sample_us;
    assign all_in[5] = housekeeping_sample_us;
    assign all_in[6] = '0;
    assign all_in[7] = '0;

    assign in_stall = wait_reg | merge_active;
    assign accept   = in_valid && !in_stall;
    assign over     = (budget_reg != '0) && (loop_sample_us > budget_reg);
    assign cmd.start = accept;
    assign cmd.n     = iter_reg + ONE;
    assign go        = wait_reg && (busy_w == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg  <= '0;
            iter_reg    <= '0;
            ob_cnt_reg  <= '0;
            ob_time_reg <= '0;
            ob_now_reg  <= 1'b0;
            wait_reg    <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr == REG_LOOP_BUDGET)
                budget_reg <= pwdata;
            if (accept)
            begin
                iter_reg   <= iter_reg + ONE;
                ob_now_reg <= over;
                wait_reg   <= 1'b1;
                if (over)
                begin
                    ob_cnt_reg  <= ob_cnt_reg + ONE;
                    ob_time_reg <= timestamp_ms;
                end
            end
            else if (go)
                wait_reg <= 1'b0;
        end
    end

    for (genvar c = 0; c < CHANNEL_COUNT; c++)
    begin : g_lane
        assign samples[c] = all_in[c];
        mcts_lane u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .cmd    (cmd),
            .sample (samples[c]),
            .busy   (busy_w[c]),
            .recent (rec_w[c]),
            .mean   (mean_w[c]),
            .peak   (peak_w[c])
        );
    end

    mcts_merge #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .go        (go),
        .recent_in (rec_w),
        .mean_in   (mean_w),
        .peak_in   (peak_w),
        .active    (merge_active),
        .valid     (out_valid),
        .stall     (out_stall),
        .index     (channel_index),
        .recent    (recent_sample_us),
        .mean      (mean_us),
        .peak      (peak_us),
        .last      (last_of_run)
    );

    assign iteration_total      = iter_reg;
    assign over_budget_total    = ob_cnt_reg;
    assign over_budget_stamp_ms = ob_time_reg;
    assign over_budget_now      = ob_now_reg;

    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> wait_reg)
        else $error("item accepted without entering compute");
    a_no_out_while_compute: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_w != '0) |-> !out_valid)
        else $error("result shown while lanes busy");
    a_go_idle: assert property (@(posedge clk) disable iff (!rst_n)
        go |-> !out_valid)
        else $error("merge started with result pending");

endmodule
